FILE: rtl/per_key_count_ranker_assert.svh
`ifndef PER_KEY_COUNT_RANKER_ASSERT_SVH
`define PER_KEY_COUNT_RANKER_ASSERT_SVH

// clocked check, switched off while reset is asserted
`define PCR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked check that also holds during reset
`define PCR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/pcr_pkg.sv
`timescale 1ns / 1ps

package pcr_pkg;

  localparam int ID_W   = 4;
  localparam int CARS_W = 16;
  localparam int CNT_W  = 16;
  localparam int TOT_W  = 32;

  localparam int QUEUE_DEPTH = 2;

  localparam int APB_ADDR_W = 2;
  localparam int APB_DATA_W = 32;

  // register map
  localparam logic [APB_ADDR_W-1:0] ADDR_REPORT_INTERVAL = 2'd0;

  localparam logic [CNT_W-1:0] REPORT_INTERVAL_RESET = 16'd48;

  // one classified record as it travels from front to back
  typedef struct packed {
    logic              report;
    logic              hit;
    logic [ID_W-1:0]   idx;
    logic [CARS_W-1:0] cars;
  } cmd_t;

endpackage

FILE: rtl/pcr_front.sv
`timescale 1ns / 1ps

module pcr_front #(
  parameter int NUM_LIGHTS = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic [pcr_pkg::ID_W-1:0]   light_id_i,
  input  logic [pcr_pkg::CARS_W-1:0] car_count_i,
  input  logic [pcr_pkg::CNT_W-1:0]  interval_i,
  output pcr_pkg::cmd_t             cmd_o
);
  import pcr_pkg::*;

  logic [CNT_W-1:0] count_q, count_d, count_inc;
  logic             report;

  assign count_inc = count_q + CNT_W'(1);
  assign report    = (count_inc == interval_i);

  // ids outside 1..NUM_LIGHTS still count as records
  always_comb begin
    cmd_o.hit    = (light_id_i != '0) && (light_id_i <= ID_W'(NUM_LIGHTS));
    cmd_o.idx    = light_id_i - ID_W'(1);
    cmd_o.cars   = car_count_i;
    cmd_o.report = report;
  end

  always_comb begin
    count_d = count_q;
    if (accept_i) begin
      count_d = report ? '0 : count_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

FILE: rtl/pcr_queue.sv
`timescale 1ns / 1ps

module pcr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pcr_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output pcr_pkg::cmd_t data_o,
  output logic          empty_o
);
  import pcr_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FILL_W-1:0] fill_q;
  logic              do_push, do_pop;

  assign full_o  = (fill_q == FILL_W'(QUEUE_DEPTH));
  assign empty_o = (fill_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    ptr_next = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + FILL_W'(1);
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - FILL_W'(1);
      end
    end
  end

endmodule

FILE: rtl/pcr_back.sv
`timescale 1ns / 1ps

module pcr_back #(
  parameter int NUM_LIGHTS = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  pcr_pkg::cmd_t             cmd_i,
  input  logic                      cmd_empty_i,
  output logic                      cmd_pop_o,
  input  logic                      pop_i,
  output logic                      out_valid_o,
  output logic [pcr_pkg::ID_W-1:0]  out_id_o,
  output logic [pcr_pkg::TOT_W-1:0] out_total_o,
  output logic                      out_last_o
);
  import pcr_pkg::*;

  localparam int IW = $clog2(NUM_LIGHTS);
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_LIGHTS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RANK,
    S_EMIT
  } state_e;

  state_e           state_q;
  logic [TOT_W-1:0] totals_q [NUM_LIGHTS];
  logic [TOT_W-1:0] sorted_tot_q [NUM_LIGHTS];
  logic [ID_W-1:0]  sorted_id_q [NUM_LIGHTS];
  logic [IW-1:0]    k_q, p_q, sel, pos;
  logic [TOT_W-1:0] cur, sat_sum;
  logic [TOT_W:0]   sum;
  logic             pop_ok, load_out;

  assign pop_ok    = pop_i && out_valid_o;
  assign cmd_pop_o = (state_q == S_IDLE) && !cmd_empty_i;
  assign load_out  = (state_q == S_EMIT) && (!out_valid_o || pop_i);

  // read select for cur: the record's light, or the light being ranked
  assign sel = (state_q == S_RANK) ? k_q : cmd_i.idx[IW-1:0];
  assign cur = totals_q[sel];

  assign sum     = {1'b0, cur} + {{(TOT_W + 1 - CARS_W){1'b0}}, cmd_i.cars};
  assign sat_sum = sum[TOT_W] ? '1 : sum[TOT_W-1:0];

  // rank position of light k: lights with a larger total, or equal and lower id
  always_comb begin
    pos = '0;
    for (int j = 0; j < NUM_LIGHTS; j++) begin
      if (IW'(j) != k_q) begin
        if ((totals_q[j] > cur) || ((totals_q[j] == cur) && (IW'(j) < k_q))) begin
          pos = pos + IW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_RANK) begin
      sorted_tot_q[pos] <= cur;
      sorted_id_q[pos]  <= ID_W'(k_q) + ID_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      p_q         <= '0;
      out_valid_o <= 1'b0;
      out_id_o    <= '0;
      out_total_o <= '0;
      out_last_o  <= 1'b0;
      for (int i = 0; i < NUM_LIGHTS; i++) begin
        totals_q[i] <= '0;
      end
    end else begin
      if (pop_ok && !load_out) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (cmd_pop_o) begin
            if (cmd_i.hit) begin
              totals_q[sel] <= sat_sum;
            end
            if (cmd_i.report) begin
              k_q     <= '0;
              state_q <= S_RANK;
            end
          end
        end
        S_RANK: begin
          k_q <= k_q + IW'(1);
          if (k_q == LAST_IDX) begin
            p_q     <= '0;
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (load_out) begin
            out_valid_o <= 1'b1;
            out_id_o    <= sorted_id_q[p_q];
            out_total_o <= sorted_tot_q[p_q];
            out_last_o  <= (p_q == LAST_IDX);
            p_q         <= p_q + IW'(1);
            if (p_q == LAST_IDX) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/per_key_count_ranker.sv
`timescale 1ns / 1ps

// Per-light car totals with a periodic ranking. Each record (light_id_i,
// car_count_i) adds its count to that light's 32-bit total, saturating at
// all ones; ids of 0 or above NUM_LIGHTS add nothing but still count as a
// record. When the record count reaches report_interval (register 0, byte
// address 0, reset 48; a value of 0 means every 65536 records) the counter
// returns to zero and NUM_LIGHTS items come out of the result register: the
// lights ranked by total, largest first, ties to the lower id, with
// rank_last_o set on the final one. Other records give no result. Writing
// the interval does not clear the record counter. A record without a
// report is taken every cycle while the queue has room and is retired
// by the back end in its idle state; a record that triggers a report
// holds the back end for one accumulate, NUM_LIGHTS ranking steps through
// a single row of NUM_LIGHTS comparators, then one result per cycle while
// the consumer pops. A two-entry queue between the front and back ends
// keeps push open during the first part of a report.
module per_key_count_ranker #(
  parameter int NUM_LIGHTS = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // record side
  input  logic                           push,
  output logic                           full,
  input  logic [pcr_pkg::ID_W-1:0]       light_id_i,
  input  logic [pcr_pkg::CARS_W-1:0]     car_count_i,
  // result side
  output logic                           empty,
  input  logic                           pop,
  output logic [pcr_pkg::ID_W-1:0]       rank_light_id_o,
  output logic [pcr_pkg::TOT_W-1:0]      rank_total_o,
  output logic                           rank_last_o,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pcr_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [pcr_pkg::APB_DATA_W-1:0] pwdata,
  output logic [pcr_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import pcr_pkg::*;

  logic [CNT_W-1:0] interval_q;
  logic             cfg_wr;
  logic             accept;
  cmd_t             front_cmd, back_cmd;
  logic             q_empty, q_pop;
  logic             out_valid;

  // configuration register, written in the apb access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_REPORT_INTERVAL);
  assign prdata = (paddr == ADDR_REPORT_INTERVAL) ?
                  {{(APB_DATA_W - CNT_W){1'b0}}, interval_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= REPORT_INTERVAL_RESET;
    end else if (cfg_wr) begin
      interval_q <= pwdata[CNT_W-1:0];
    end
  end

  // an item is taken whenever the queue to the back end has room
  assign accept = push && !full;

  pcr_front #(.NUM_LIGHTS(NUM_LIGHTS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .light_id_i  (light_id_i),
    .car_count_i (car_count_i),
    .interval_i  (interval_q),
    .cmd_o       (front_cmd)
  );

  pcr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (front_cmd),
    .full_o  (full),
    .pop_i   (q_pop),
    .data_o  (back_cmd),
    .empty_o (q_empty)
  );

  // back end: accumulate, rank on report, drain through the result register
  pcr_back #(.NUM_LIGHTS(NUM_LIGHTS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (back_cmd),
    .cmd_empty_i (q_empty),
    .cmd_pop_o   (q_pop),
    .pop_i       (pop),
    .out_valid_o (out_valid),
    .out_id_o    (rank_light_id_o),
    .out_total_o (rank_total_o),
    .out_last_o  (rank_last_o)
  );

  assign empty = !out_valid;

endmodule

FILE: rtl/pcr_checker.sv
`timescale 1ns / 1ps

`include "per_key_count_ranker_assert.svh"

module pcr_checker #(
  parameter int NUM_LIGHTS = 4
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           empty,
  input logic                           pop,
  input logic [pcr_pkg::ID_W-1:0]       rank_light_id_o,
  input logic [pcr_pkg::TOT_W-1:0]      rank_total_o,
  input logic                           rank_last_o,
  input logic                           psel,
  input logic                           penable,
  input logic                           pwrite,
  input logic [pcr_pkg::APB_ADDR_W-1:0] paddr,
  input logic [pcr_pkg::APB_DATA_W-1:0] pwdata,
  input logic [pcr_pkg::APB_DATA_W-1:0] prdata
);
  import pcr_pkg::*;

  // nothing waits on the result side while reset is held
  `PCR_ASSERT_ALWAYS(a_empty_in_reset, clk_i, !rst_ni |-> empty, "result present in reset")

  // a waiting result stays until popped
  `PCR_ASSERT(a_result_holds, clk_i, rst_ni, (!empty && !pop) |=> (!empty && $stable(rank_total_o) && $stable(rank_light_id_o)), "result dropped while stalled")

  // the ranking drains without gaps and in non-increasing order of total
  `PCR_ASSERT(a_rank_descends, clk_i, rst_ni, (!empty && pop && !rank_last_o) |=> (!empty && (rank_total_o <= $past(rank_total_o))), "ranking out of order or broken")

  // ranked ids are real lights
  `PCR_ASSERT(a_id_in_range, clk_i, rst_ni, !empty |-> ((rank_light_id_o != '0) && (rank_light_id_o <= ID_W'(NUM_LIGHTS))), "ranked id out of range")

  // the interval register reads back what was written
  `PCR_ASSERT(a_cfg_readback, clk_i, rst_ni, (psel && penable && pwrite && (paddr == ADDR_REPORT_INTERVAL)) |=> ((paddr != ADDR_REPORT_INTERVAL) || (prdata[CNT_W-1:0] == $past(pwdata[CNT_W-1:0]))), "interval readback mismatch")

endmodule

bind per_key_count_ranker pcr_checker #(.NUM_LIGHTS(NUM_LIGHTS)) u_pcr_checker (.*);
